// File: hdl/uf2bf_pkg.sv
// Shared constants and types for the UF2 block framer.
// Used by uf2bf_header and uf2_block_framer; depends on nothing else.
package uf2bf_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 256;
  localparam int unsigned HDR_WORDS         = 4;
  localparam int unsigned BLOCK_WORDS       = 64;
  localparam int unsigned POS_W             = 6;
  localparam int unsigned CFG_IDX_W         = 2;

  localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
  localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
  localparam logic [31:0] UF2_FLAGS    = 32'h0000_2000;

  localparam logic [31:0] FAMILY_ID_RST    = 32'hE48B_FF56;
  localparam logic [31:0] BASE_ADDRESS_RST = 32'h0000_0000;
  localparam logic [31:0] TOTAL_BLOCKS_RST = 32'h0000_0001;

  localparam logic [CFG_IDX_W-1:0] CFG_FAMILY_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd2;

  localparam logic [1:0] HDR_MAGIC = 2'd0;
  localparam logic [1:0] HDR_ADDR  = 2'd1;
  localparam logic [1:0] HDR_SIZE  = 2'd2;
  localparam logic [1:0] HDR_ID    = 2'd3;

  typedef struct packed {
    logic advance;
    logic restart;
  } blk_ctl_t;

endpackage

// File: hdl/uf2bf_header.sv
// Configuration registers, block counters and header doubleword selection.
// Depends on uf2bf_pkg.
module uf2bf_header #(
  parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [uf2bf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  uf2bf_pkg::blk_ctl_t            blk_ctl,
  input  logic [1:0]                     hdr_idx,
  output logic [63:0]                    hdr_word
);

  localparam logic [31:0] PAYLOAD_SIZE = 32'(PAYLOAD_BYTES);

  logic [31:0] family_id_r, family_id_nxt;
  logic [31:0] base_address_r, base_address_nxt;
  logic [31:0] total_blocks_r, total_blocks_nxt;
  logic [31:0] block_number_r, block_number_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] addr;

  always_comb begin
    family_id_nxt    = family_id_r;
    base_address_nxt = base_address_r;
    total_blocks_nxt = total_blocks_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        uf2bf_pkg::CFG_FAMILY_ID:    family_id_nxt    = cfg_data;
        uf2bf_pkg::CFG_BASE_ADDRESS: base_address_nxt = cfg_data;
        uf2bf_pkg::CFG_TOTAL_BLOCKS: total_blocks_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    block_number_nxt = block_number_r;
    offset_nxt       = offset_r;
    if (blk_ctl.advance) begin
      if (blk_ctl.restart) begin
        block_number_nxt = '0;
        offset_nxt       = '0;
      end else begin
        block_number_nxt = block_number_r + 32'd1;
        offset_nxt       = offset_r + PAYLOAD_SIZE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_id_r    <= uf2bf_pkg::FAMILY_ID_RST;
      base_address_r <= uf2bf_pkg::BASE_ADDRESS_RST;
      total_blocks_r <= uf2bf_pkg::TOTAL_BLOCKS_RST;
      block_number_r <= '0;
      offset_r       <= '0;
    end else begin
      family_id_r    <= family_id_nxt;
      base_address_r <= base_address_nxt;
      total_blocks_r <= total_blocks_nxt;
      block_number_r <= block_number_nxt;
      offset_r       <= offset_nxt;
    end
  end

  // The offset register holds block_number * payload size, so the address needs one add.
  assign addr = base_address_r + offset_r;

  always_comb begin
    unique case (hdr_idx)
      uf2bf_pkg::HDR_MAGIC: hdr_word = {uf2bf_pkg::MAGIC_START1, uf2bf_pkg::MAGIC_START0};
      uf2bf_pkg::HDR_ADDR:  hdr_word = {addr, uf2bf_pkg::UF2_FLAGS};
      uf2bf_pkg::HDR_SIZE:  hdr_word = {block_number_r, PAYLOAD_SIZE};
      uf2bf_pkg::HDR_ID:    hdr_word = {family_id_r, total_blocks_r};
      default:              hdr_word = '0;
    endcase
  end

endmodule

// File: hdl/uf2_block_framer.sv
// Top level of the UF2 block framer: input holding register, block sequencer, output register.
// Depends on uf2bf_pkg and uf2bf_header.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------------
//   in      | input     | in_valid / in_ready   | in_image_bytes[63:0], in_final_item
//   out     | output    | out_valid / out_ready | out_word[63:0], out_block_end, out_stream_end
//   cfg     | input     | cfg_wr_en             | cfg_index[1:0], cfg_data[31:0]
//
// One output beat leaves per cycle while an input beat is held and the output is not stalled;
// a block is 64 beats. A mid-block input beat is released as its data beat is emitted, the first
// of a block stays held while the four header beats go out, and the closing one runs on through
// the zero fill to the end magic. Reset is synchronous and needs no clearing pass.
// A stalled output holds its beat while the next input beat still waits in the holding register.
module uf2_block_framer #(
  parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [uf2bf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    in_image_bytes,
  input  logic                           in_final_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    out_word,
  output logic                           out_block_end,
  output logic                           out_stream_end
);

  localparam int unsigned POS_W      = uf2bf_pkg::POS_W;
  localparam int unsigned DATA_WORDS = PAYLOAD_BYTES / 8;
  localparam logic [POS_W-1:0] POS_LAST_DATA =
    POS_W'(uf2bf_pkg::HDR_WORDS + DATA_WORDS - 1);
  localparam logic [POS_W-1:0] POS_END = POS_W'(uf2bf_pkg::BLOCK_WORDS - 1);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(uf2bf_pkg::HDR_WORDS);

  logic              hold_v_r, hold_v_nxt;
  logic [63:0]       hold_bytes_r;
  logic              hold_final_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_word_r;
  logic              out_block_end_r;
  logic              out_stream_end_r;

  logic              emit, is_hdr, is_data, is_end, close, release_item, accept;
  logic [63:0]       hdr_word, word;
  uf2bf_pkg::blk_ctl_t blk_ctl;

  assign emit         = hold_v_r && (!out_valid_r || out_ready);
  assign is_hdr       = !fill_r && (pos_r < POS_HDR);
  assign is_data      = !fill_r && !is_hdr;
  assign is_end       = fill_r && (pos_r == POS_END);
  assign close        = hold_final_r || (pos_r == POS_LAST_DATA);
  assign release_item = emit && ((is_data && !close) || is_end);
  assign in_ready     = !hold_v_r || release_item;
  assign accept       = in_valid && in_ready;

  assign blk_ctl.advance = emit && is_end;
  assign blk_ctl.restart = hold_final_r;

  uf2bf_header #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_header (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .blk_ctl  (blk_ctl),
    .hdr_idx  (pos_r[1:0]),
    .hdr_word (hdr_word)
  );

  always_comb begin
    if (is_hdr) begin
      word = hdr_word;
    end else if (is_data) begin
      word = hold_bytes_r;
    end else if (is_end) begin
      word = {uf2bf_pkg::MAGIC_END, 32'h0000_0000};
    end else begin
      word = '0;
    end
  end

  always_comb begin
    hold_v_nxt    = hold_v_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (release_item) begin
      hold_v_nxt = 1'b0;
    end
    if (accept) begin
      hold_v_nxt = 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (is_end) begin
        pos_nxt  = '0;
        fill_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (is_data && close) begin
          fill_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      pos_r       <= '0;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_bytes_r <= in_image_bytes;
      hold_final_r <= in_final_item;
    end
    if (emit) begin
      out_word_r       <= word;
      out_block_end_r  <= is_end;
      out_stream_end_r <= is_end && hold_final_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_block_end  = out_block_end_r;
  assign out_stream_end = out_stream_end_r;

  a_end_magic: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_block_end_r) |-> (out_word_r[63:32] == uf2bf_pkg::MAGIC_END))
    else $error("closing beat lacks the end magic");

  a_stream_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stream_end_r) |-> out_block_end_r)
    else $error("stream end flagged off a block boundary");

  a_fill_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r |-> hold_v_r)
    else $error("zero fill running without a held item");

  a_block_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_end) |=> (pos_r == '0 && !fill_r))
    else $error("sequencer did not return to the header after the end magic");

  a_header_first: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r < POS_HDR) |-> !fill_r)
    else $error("zero fill inside the header");

endmodule

// File: test/testbench.sv
// Self-checking testbench for uf2_block_framer: image beats go in, UF2 doublewords are predicted
// and compared beat by beat with what the block sends out.
// Depends on uf2bf_pkg and the uf2_block_framer RTL only.
`timescale 1ns / 100ps

module testbench;

  localparam int          DATA_WORDS   = uf2bf_pkg::PAYLOAD_BYTES_DEF / 8;
  localparam int          ZERO_WORDS   = int'(uf2bf_pkg::BLOCK_WORDS)
                                         - int'(uf2bf_pkg::HDR_WORDS) - DATA_WORDS - 1;
  localparam logic [31:0] PAYLOAD_SIZE = uf2bf_pkg::PAYLOAD_BYTES_DEF;
  localparam logic [uf2bf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int          STALL_CYCLES = 400;
  localparam int          STUCK_LIMIT  = 2000;

  typedef struct {
    logic [63:0] word;
    logic        block_end;
    logic        stream_end;
  } uf2_beat_t;

  logic                            clk;
  logic                            rst_n          = 1'b0;
  logic                            cfg_wr_en      = 1'b0;
  logic [uf2bf_pkg::CFG_IDX_W-1:0] cfg_index      = uf2bf_pkg::CFG_FAMILY_ID;
  logic [31:0]                     cfg_data       = '0;
  logic                            in_valid       = 1'b0;
  logic                            in_ready;
  logic [63:0]                     in_image_bytes = '0;
  logic                            in_final_item  = 1'b0;
  logic                            out_valid;
  logic                            out_ready      = 1'b0;
  logic [63:0]                     out_word;
  logic                            out_block_end;
  logic                            out_stream_end;

  uf2_beat_t   uf2_beats_due[$];
  logic [31:0] family_id_reg    = uf2bf_pkg::FAMILY_ID_RST;
  logic [31:0] base_address_reg = uf2bf_pkg::BASE_ADDRESS_RST;
  logic [31:0] total_blocks_reg = uf2bf_pkg::TOTAL_BLOCKS_RST;
  logic [31:0] block_count      = '0;
  int          words_in_block   = 0;

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic stall_req    = 1'b0;
  int   stall_left   = 0;
  int   stuck_cycles = 0;
  int   fail_count   = 0;

  uf2_block_framer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_image_bytes (in_image_bytes),
    .in_final_item  (in_final_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .out_block_end  (out_block_end),
    .out_stream_end (out_stream_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic queue_uf2_beat(input logic [63:0] word, input logic bend, input logic send);
    uf2_beat_t beat;
    beat.word       = word;
    beat.block_end  = bend;
    beat.stream_end = send;
    uf2_beats_due.push_back(beat);
  endtask

  task automatic frame_image_beat(input logic [63:0] bytes, input logic fin);
    logic [31:0] addr;
    if (words_in_block == 0) begin
      addr = base_address_reg + block_count * PAYLOAD_SIZE;
      queue_uf2_beat({uf2bf_pkg::MAGIC_START1, uf2bf_pkg::MAGIC_START0}, 1'b0, 1'b0);
      queue_uf2_beat({addr, uf2bf_pkg::UF2_FLAGS}, 1'b0, 1'b0);
      queue_uf2_beat({block_count, PAYLOAD_SIZE}, 1'b0, 1'b0);
      queue_uf2_beat({family_id_reg, total_blocks_reg}, 1'b0, 1'b0);
    end
    queue_uf2_beat(bytes, 1'b0, 1'b0);
    words_in_block++;
    if (fin || words_in_block >= DATA_WORDS) begin
      repeat (DATA_WORDS - words_in_block + ZERO_WORDS) queue_uf2_beat('0, 1'b0, 1'b0);
      queue_uf2_beat({uf2bf_pkg::MAGIC_END, 32'h0}, 1'b1, fin);
      words_in_block = 0;
      block_count    = fin ? 32'h0 : block_count + 32'h1;
    end
  endtask

  task automatic write_reg(input logic [uf2bf_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      uf2bf_pkg::CFG_FAMILY_ID:    family_id_reg    = value;
      uf2bf_pkg::CFG_BASE_ADDRESS: base_address_reg = value;
      uf2bf_pkg::CFG_TOTAL_BLOCKS: total_blocks_reg = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] family, input logic [31:0] base,
                           input logic [31:0] total);
    write_reg(uf2bf_pkg::CFG_FAMILY_ID, family);
    write_reg(uf2bf_pkg::CFG_BASE_ADDRESS, base);
    write_reg(uf2bf_pkg::CFG_TOTAL_BLOCKS, total);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_reg_value(input logic [31:0] lo_val,
                                                 input logic [31:0] hi_val);
    case ($urandom_range(3))
      0:       return lo_val;
      1:       return hi_val;
      default: return $urandom_range(hi_val, lo_val);
    endcase
  endfunction

  task automatic configure_random();
    configure(pick_reg_value(32'h0, 32'hFFFF_FFFF), pick_reg_value(32'h0, 32'hFFFF_FFFF),
              pick_reg_value(32'h1, 32'hFFFF_FFFF));
  endtask

  task automatic send_beat(input logic [63:0] bytes, input logic fin);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_image_bytes <= bytes;
    in_final_item  <= fin;
    do @(posedge clk); while (!in_ready);
    frame_image_beat(bytes, fin);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (uf2_beats_due.size() != 0);
  endtask

  function automatic logic [63:0] random_bytes();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_image(input int len);
    for (int k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(49) == 0) begin
        wait_drained();
        configure_random();
      end
      send_beat(random_bytes(), k == len - 1);
    end
  endtask

  task automatic test_reset_values();
    send_beat(random_bytes(), 1'b1);
    wait_drained();
  endtask

  task automatic test_data_patterns();
    send_beat(64'h0, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_beat(64'h5555_5555_5555_5555, 1'b0);
    send_beat(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_beat(64'h0123_4567_89AB_CDEF, 1'b0);
    send_beat(64'hFEDC_BA98_7654_3210, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    configure(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) send_beat(random_bytes(), 1'b0);
    wait_drained();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    configure(32'hFFFF_FFFF, 32'h0, 32'h1);
    send_beat(random_bytes(), 1'b1);
    send_beat(random_bytes(), 1'b1);
    wait_drained();
  endtask

  task automatic test_output_stall();
    stall_req <= 1'b1;
    @(posedge clk);
    stall_req <= 1'b0;
    send_image(DATA_WORDS + 8);
    wait_drained();
  endtask

  task automatic test_random_images(input int send_pct, input int recv_pct, input int beats);
    int sent;
    int len;
    tx_idle_pct = send_pct;
    rx_idle_pct <= recv_pct;
    sent = 0;
    wait_drained();
    configure_random();
    while (sent < beats) begin
      case ($urandom_range(7))
        0:       len = 1;
        1:       len = DATA_WORDS;
        2:       len = DATA_WORDS + 1;
        3:       len = 2 * DATA_WORDS;
        default: len = $urandom_range(DATA_WORDS - 1, 2);
      endcase
      send_image(len);
      sent += len;
      if ($urandom_range(3) == 0) begin
        wait_drained();
        configure_random();
      end
    end
    wait_drained();
  endtask

  initial begin
    tx_idle_pct = 22;
    rx_idle_pct <= 56;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_data_patterns();
    test_register_extremes();
    test_output_stall();
    test_random_images(22, 56, 110);
    test_random_images(56, 22, 110);
    test_random_images(0, 0, 120);
    wait_drained();
    repeat (2 * uf2bf_pkg::BLOCK_WORDS) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // The long stall is counted here so that the sender carries on offering beats meanwhile.
  always @(posedge clk) begin
    if (stall_req || stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_req ? STALL_CYCLES : stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_output
    uf2_beat_t due;
    if (rst_n && out_valid && out_ready) begin
      if (uf2_beats_due.size() == 0) begin
        $error("unexpected output beat: out_word %h", out_word);
        fail_count++;
      end else begin
        due = uf2_beats_due.pop_front();
        if (out_word !== due.word) begin
          $error("out_word: expected %h, actual %h", due.word, out_word);
          fail_count++;
        end
        if (out_block_end !== due.block_end) begin
          $error("out_block_end: expected %b, actual %b", due.block_end, out_block_end);
          fail_count++;
        end
        if (out_stream_end !== due.stream_end) begin
          $error("out_stream_end: expected %b, actual %b", due.stream_end, out_stream_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
